@@ rtl/m3i_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse block.
// Holds the input and result word layouts. No dependencies.
package m3i_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int EPS_WIDTH      = 16;
    localparam int EPS_RESET      = 1;

    typedef logic signed [DATA_WIDTH-1:0] t_ent;

    typedef struct packed {
        t_ent a11; t_ent a12; t_ent a13;
        t_ent a21; t_ent a22; t_ent a23;
        t_ent a31; t_ent a32; t_ent a33;
    } t_in_word;

    typedef struct packed {
        t_ent r11; t_ent r12; t_ent r13;
        t_ent r21; t_ent r22; t_ent r23;
        t_ent r31; t_ent r32; t_ent r33;
        t_ent det_value;
        logic singular;
        logic saturated;
    } t_out_word;

    // row-major entry k of a matrix word
    function automatic t_ent m3i_entry(t_in_word w, int k);
        logic [8:0][DATA_WIDTH-1:0] v;
        v = w;
        return t_ent'(v[8-k]);
    endfunction

    // the two other rows (or columns) of a minor
    function automatic int m3i_lo(int i);
        return (i == 0) ? 1 : 0;
    endfunction

    function automatic int m3i_hi(int i);
        return (i == 2) ? 1 : 2;
    endfunction

endpackage

@@ rtl/matrix3x3_inverse.sv @@
// 3x3 signed fixed-point matrix inverse by the adjugate, fully pipelined.
// Depends on m3i_pkg and m3i_div.
//
// Input channel i_valid/o_ready/i_data carries one matrix word (a11..a33).
// Output channel o_valid/i_ready/o_data carries the inverse, the rounded
// determinant and the singular and saturated flags. Config channel
// i_cfg_valid/o_cfg_ready/i_cfg_data writes the singular epsilon; it is
// always ready and should be written while the block is idle.
//
// A word enters every cycle while o_ready is high. The pipeline holds eight
// stages of products, cofactors, determinant and numerator setup, one divider
// stage per quotient bit and one saturate stage. The depth of the divider sets
// most of the latency; throughput is one per cycle unless the output stalls.
//
// Reset clears all valid bits and sets epsilon to 1. When the receiver
// stalls, one more word lands in a skid register, then o_ready drops and
// the whole pipeline holds until the output is taken.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = m3i_pkg::DEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  m3i_pkg::t_in_word              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output m3i_pkg::t_out_word             o_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [m3i_pkg::EPS_WIDTH-1:0]  i_cfg_data
);
    import m3i_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DW;
    localparam int CW   = 2 * DW + 1;
    localparam int CMW  = 2 * DW;
    localparam int DETW = 3 * DW + 1;
    localparam int MW   = 3 * DW;
    localparam int NSH  = CMW + 2 * FRAC_BITS + 1;
    localparam int NW   = ((NSH > MW) ? NSH : MW) + 1;
    localparam int DENW = MW + 1;
    localparam int QW   = DW;
    localparam int PRE  = 8;
    localparam int NSTG = PRE + QW;

    typedef struct packed {
        logic       sing;
        t_ent       detv;
        logic [8:0] sgn;
        logic [8:0] ovf;
    } t_side;

    logic            en;
    logic [NSTG-1:0] r_vld;
    t_in_word        r_mat [NSTG];
    logic [EPS_WIDTH-1:0] r_eps;

    logic signed [DW-1:0]   a_in  [3][3];
    logic signed [PW-1:0]   r_pa  [3][3];
    logic signed [PW-1:0]   r_pb  [3][3];
    logic signed [CW-1:0]   r_cof [4][3][3];
    logic signed [CW-1:0]   r_plo [3];
    logic signed [CW-1:0]   r_phi [3];
    logic signed [DETW-1:0] r_term [3];
    logic signed [DETW-1:0] r_det;
    logic                   r_dneg;
    logic [MW-1:0]          r_dmag;
    logic [CMW-1:0]         r_cmag [3][3];
    logic                   r_cneg [3][3];
    logic [NW-1:0]          r_num_g [9];
    logic [8:0]             r_sgn_g;
    logic [DENW-1:0]        r_den_g;
    logic                   r_sing_g;
    t_ent                   r_detv_g;
    logic [NW-1:0]          r_num_h [9];
    logic [DENW-1:0]        r_den_h;
    t_side                  r_side [QW+1];
    logic [QW-1:0]          quo [9];

    t_out_word r_out, r_skid, d_out;
    logic      r_out_v, r_skid_v;

    assign en          = !r_skid_v;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_WIDTH'(EPS_RESET);
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a_in[i][j] = m3i_entry(i_data, i * 3 + j);
    end

    function automatic t_ent det_round(logic [MW-1:0] mag, logic neg);
        logic [MW:0] dr;
        logic [MW:0] dlim;
        logic [MW:0] dm;
        dr   = ({1'b0, mag} + ((MW+1)'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        dlim = ((MW+1)'(1) << (DW - 1)) - (MW+1)'(!neg);
        dm   = (dr > dlim) ? dlim : dr;
        if (neg)
            dm = (MW+1)'(0) - dm;
        return t_ent'(dm[DW-1:0]);
    endfunction

    // stages A..H
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mat[0] <= i_data;
            for (int k = 1; k < NSTG; k++)
                r_mat[k] <= r_mat[k-1];

            // A: minor products
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    r_pa[i][j] <= a_in[m3i_lo(i)][m3i_lo(j)] * a_in[m3i_hi(i)][m3i_hi(j)];
                    r_pb[i][j] <= a_in[m3i_lo(i)][m3i_hi(j)] * a_in[m3i_hi(i)][m3i_lo(j)];
                end

            // B: signed cofactors
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    if (((i + j) % 2) == 1)
                        r_cof[0][i][j] <= CW'(r_pb[i][j]) - CW'(r_pa[i][j]);
                    else
                        r_cof[0][i][j] <= CW'(r_pa[i][j]) - CW'(r_pb[i][j]);
                end
            for (int k = 1; k < 4; k++)
                r_cof[k] <= r_cof[k-1];

            // C: row-1 terms split into low and high halves of the cofactor
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= m3i_entry(r_mat[1], j) * $signed({1'b0, r_cof[0][0][j][DW-1:0]});
                r_phi[j] <= m3i_entry(r_mat[1], j) * $signed(r_cof[0][0][j][CW-1:DW]);
            end

            // D: rejoin halves
            for (int j = 0; j < 3; j++)
                r_term[j] <= (DETW'(r_phi[j]) <<< DW) + DETW'(r_plo[j]);

            // E: determinant
            r_det <= r_term[0] + r_term[1] + r_term[2];

            // F: magnitudes and signs
            r_dneg <= r_det[DETW-1];
            r_dmag <= r_det[DETW-1] ? MW'(-r_det) : MW'(r_det);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    r_cneg[i][j] <= r_cof[3][i][j][CW-1];
                    r_cmag[i][j] <= r_cof[3][i][j][CW-1] ? CMW'(-r_cof[3][i][j])
                                                         : CMW'(r_cof[3][i][j]);
                end

            // G: numerators of the rounded quotients, transposed
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    r_num_g[i*3+j] <= (NW'(r_cmag[j][i]) << (2 * FRAC_BITS + 1))
                                      + NW'(r_dmag);
                    r_sgn_g[i*3+j] <= r_cneg[j][i] ^ r_dneg;
                end
            r_den_g  <= DENW'(r_dmag) << 1;
            r_sing_g <= r_dmag <= (MW'(r_eps) << (2 * FRAC_BITS));
            r_detv_g <= det_round(r_dmag, r_dneg);

            // H: quotient overflow check
            for (int k = 0; k < 9; k++) begin
                r_num_h[k]     <= r_num_g[k];
                r_side[0].ovf[k] <= (r_num_g[k] >> DW) >= NW'(r_den_g);
            end
            r_den_h         <= r_den_g;
            r_side[0].sgn   <= r_sgn_g;
            r_side[0].sing  <= r_sing_g;
            r_side[0].detv  <= r_detv_g;
            for (int k = 1; k <= QW; k++)
                r_side[k] <= r_side[k-1];
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_div
        m3i_div #(
            .NW   (NW),
            .DENW (DENW),
            .QW   (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num_h[k]),
            .i_den (r_den_h),
            .o_quo (quo[k])
        );
    end

    // saturate and pick the result
    always_comb begin
        logic [8:0][DW-1:0] rv;
        logic [8:0]         clip;
        logic [QW-1:0]      lim;
        logic [QW-1:0]      m;
        t_side              sd;
        sd = r_side[QW];
        for (int k = 0; k < 9; k++) begin
            lim     = (QW'(1) << (DW - 1)) - QW'(!sd.sgn[k]);
            clip[k] = sd.ovf[k] || (quo[k] > lim);
            m       = clip[k] ? lim : quo[k];
            if (sd.sing)
                rv[8-k] = m3i_entry(r_mat[NSTG-1], k);
            else
                rv[8-k] = sd.sgn[k] ? DW'(QW'(0) - m) : DW'(m);
        end
        d_out = t_out_word'({rv, sd.detv, sd.sing, !sd.sing && (|clip)});
    end

    // output register with one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (r_out_v && !i_ready)
                r_skid_v <= r_vld[NSTG-1];
            else
                r_out_v <= r_vld[NSTG-1];
        end else if (i_ready) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_out_v && !i_ready)
                r_skid <= d_out;
            else
                r_out <= d_out;
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

@@ rtl/m3i_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Data only; valid travels with the caller. Uses no package items.
module m3i_div #(
    parameter int NW   = 98,
    parameter int DENW = 97,
    parameter int QW   = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [NW-1:0]   i_num,
    input  logic [DENW-1:0] i_den,
    output logic [QW-1:0]   o_quo
);
    localparam int RW = DENW + QW;

    logic [RW-1:0]   r_rem [QW];
    logic [DENW-1:0] r_dd  [QW];
    logic [QW-1:0]   r_q   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stg
        logic [RW-1:0]   rem_in;
        logic [RW-1:0]   sub_v;
        logic [DENW-1:0] den_in;
        logic [QW-1:0]   q_in;

        if (s == 0) begin : g_first
            assign rem_in = RW'(i_num);
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_dd[s-1];
            assign q_in   = r_q[s-1];
        end

        assign sub_v = RW'(den_in) << (QW - 1 - s);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[s] <= den_in;
                if (rem_in >= sub_v) begin
                    r_rem[s] <= rem_in - sub_v;
                    r_q[s]   <= q_in | (QW'(1) << (QW - 1 - s));
                end else begin
                    r_rem[s] <= rem_in;
                    r_q[s]   <= q_in;
                end
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

@@ rtl/m3i_chk.sv @@
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
// Depends on m3i_pkg.
module m3i_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input m3i_pkg::t_out_word  o_data
);
    import m3i_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    // a singular matrix never reports clipping
    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> !o_data.saturated)
        else $error("singular word flagged saturated");

    // input backpressure only while a result waits
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    // backpressure starts only after an output stall
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid && !i_ready))
        else $error("input stalled without an output stall");

endmodule

bind matrix3x3_inverse m3i_chk u_m3i_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

@@ dv/tb.sv @@
// Self-checking testbench for matrix3x3_inverse: random and directed matrices,
// predicted inverse/determinant/flags compared word by word.
// Depends on m3i_pkg and the matrix3x3_inverse RTL.
module tb;
    import m3i_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int LAT  = 9 + DATA_WIDTH;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_ready = 0, i_cfg_valid = 0;
    logic [EPS_WIDTH-1:0] i_cfg_data = '0;
    t_in_word  i_data = '0;
    logic o_ready, o_valid, o_cfg_ready;
    t_out_word o_data;

    t_in_word  pending_mats[$];
    t_out_word expected_inv[$];
    logic [EPS_WIDTH-1:0] eps_now = EPS_RESET;
    int bad_count = 0;
    bit no_gaps = 0;
    int in_gap = 0, out_gap = 0;

    matrix3x3_inverse uut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_ent clip_entry(logic [191:0] q, bit neg, inout bit clipped);
        logic [191:0] lim;
        lim = (192'd1 << (DATA_WIDTH - 1)) - (neg ? 192'd0 : 192'd1);
        if (q > lim) begin
            q = lim;
            clipped = 1;
        end
        return neg ? t_ent'(-q[DATA_WIDTH-1:0]) : t_ent'(q[DATA_WIDTH-1:0]);
    endfunction

    function automatic t_out_word invert(t_in_word w);
        logic signed [127:0] m[3][3], cof[3][3], det;
        logic [191:0] dmag, num, den, q;
        logic [127:0] cmag;
        bit dneg, cneg, clipped, unused;
        int r0, r1, c0, c1;
        t_out_word res;
        m[0][0] = w.a11; m[0][1] = w.a12; m[0][2] = w.a13;
        m[1][0] = w.a21; m[1][1] = w.a22; m[1][2] = w.a23;
        m[2][0] = w.a31; m[2][1] = w.a32; m[2][2] = w.a33;
        for (int i = 0; i < 3; i++) begin
            r0 = i == 0 ? 1 : 0;
            r1 = i == 2 ? 1 : 2;
            for (int j = 0; j < 3; j++) begin
                c0 = j == 0 ? 1 : 0;
                c1 = j == 2 ? 1 : 2;
                cof[i][j] = m[r0][c0] * m[r1][c1] - m[r0][c1] * m[r1][c0];
                if ((i + j) % 2) cof[i][j] = -cof[i][j];
            end
        end
        det = m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2];
        dneg = det < 0;
        dmag = dneg ? 192'(-det) : 192'(det);
        // determinant carries 3*FRAC fraction bits
        q = (dmag + (192'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        unused = 0;
        res.det_value = clip_entry(q, dneg, unused);
        res.singular = dmag <= (192'(eps_now) << (2 * FRAC));
        clipped = 0;
        if (res.singular) begin
            {res.r11, res.r12, res.r13, res.r21, res.r22, res.r23,
             res.r31, res.r32, res.r33} = w;
        end else begin
            den = dmag << 1;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    cneg = cof[j][i] < 0;
                    cmag = cneg ? -cof[j][i] : cof[j][i];
                    num = (192'(cmag) << (2 * FRAC + 1)) + dmag;
                    q = num / den;
                    case (i * 3 + j)
                        0: res.r11 = clip_entry(q, cneg != dneg, clipped);
                        1: res.r12 = clip_entry(q, cneg != dneg, clipped);
                        2: res.r13 = clip_entry(q, cneg != dneg, clipped);
                        3: res.r21 = clip_entry(q, cneg != dneg, clipped);
                        4: res.r22 = clip_entry(q, cneg != dneg, clipped);
                        5: res.r23 = clip_entry(q, cneg != dneg, clipped);
                        6: res.r31 = clip_entry(q, cneg != dneg, clipped);
                        7: res.r32 = clip_entry(q, cneg != dneg, clipped);
                        default: res.r33 = clip_entry(q, cneg != dneg, clipped);
                    endcase
                end
        end
        res.saturated = clipped;
        return res;
    endfunction

    task automatic report_bad(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        bad_count++;
    endtask

    task automatic check_word(t_out_word got, t_out_word want);
        if (got.r11 !== want.r11) report_bad("r11", got.r11, want.r11);
        if (got.r12 !== want.r12) report_bad("r12", got.r12, want.r12);
        if (got.r13 !== want.r13) report_bad("r13", got.r13, want.r13);
        if (got.r21 !== want.r21) report_bad("r21", got.r21, want.r21);
        if (got.r22 !== want.r22) report_bad("r22", got.r22, want.r22);
        if (got.r23 !== want.r23) report_bad("r23", got.r23, want.r23);
        if (got.r31 !== want.r31) report_bad("r31", got.r31, want.r31);
        if (got.r32 !== want.r32) report_bad("r32", got.r32, want.r32);
        if (got.r33 !== want.r33) report_bad("r33", got.r33, want.r33);
        if (got.det_value !== want.det_value)
            report_bad("det_value", got.det_value, want.det_value);
        if (got.singular !== want.singular)
            report_bad("singular", got.singular, want.singular);
        if (got.saturated !== want.saturated)
            report_bad("saturated", got.saturated, want.saturated);
    endtask

    // input driver; predicts on each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            in_gap <= 0;
        end else begin
            if (i_valid && o_ready) expected_inv.push_back(invert(i_data));
            if (!i_valid || o_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_valid <= 0;
                end else if (pending_mats.size() > 0) begin
                    i_data <= pending_mats.pop_front();
                    i_valid <= 1;
                    in_gap <= pick_gap();
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // output monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            out_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_inv.size() == 0)
                    report_bad("unexpected result word", '0, '0);
                else
                    check_word(o_data, expected_inv.pop_front());
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 0;
            end else begin
                i_ready <= 1;
                out_gap <= pick_gap();
            end
        end
    end

    function automatic t_ent rand_entry(int kind);
        case (kind)
            0: return t_ent'($urandom());
            1: return t_ent'($urandom_range(0, 1 << 19)) - t_ent'(1 << 18);
            default: return t_ent'($urandom_range(0, 1 << 13)) - t_ent'(1 << 12);
        endcase
    endfunction

    function automatic t_in_word rand_matrix();
        t_in_word w;
        int kind;
        kind = $urandom_range(0, 9);
        w = {rand_entry(kind % 3), rand_entry(kind % 3), rand_entry(kind % 3),
             rand_entry(kind % 3), rand_entry(kind % 3), rand_entry(kind % 3),
             rand_entry(kind % 3), rand_entry(kind % 3), rand_entry(kind % 3)};
        // near-singular: third row close to the first
        if (kind == 9) begin
            w.a31 = w.a11 + t_ent'($urandom_range(0, 3));
            w.a32 = w.a12;
            w.a33 = w.a13 - t_ent'($urandom_range(0, 3));
        end
        return w;
    endfunction

    function automatic t_in_word diag(t_ent d1, t_ent d2, t_ent d3);
        return {d1, t_ent'(0), t_ent'(0), t_ent'(0), d2, t_ent'(0),
                t_ent'(0), t_ent'(0), d3};
    endfunction

    task automatic wait_idle();
        while (pending_mats.size() > 0 || i_valid || expected_inv.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [EPS_WIDTH-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        eps_now = v;
        i_cfg_valid <= 0;
    endtask

    initial begin
        logic [EPS_WIDTH-1:0] eps_list[4];
        t_ent one, mx, mn;
        one = t_ent'(1 << FRAC);
        mx = t_ent'(32'h7fff_ffff);
        mn = t_ent'(32'h8000_0000);
        eps_list = '{16'd1, 16'd0, 16'hffff, 16'd0};
        eps_list[3] = EPS_WIDTH'($urandom_range(2, 65534));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset epsilon first
        pending_mats.push_back(diag(one, one, one));
        pending_mats.push_back('0);
        pending_mats.push_back({9{mx}});
        pending_mats.push_back({9{mn}});
        pending_mats.push_back(diag(mx, mx, mx));
        pending_mats.push_back(diag(mn, mx, mn));
        pending_mats.push_back(diag(mn, mn, mn));
        pending_mats.push_back(diag(one * 2, -one, one / 4));
        pending_mats.push_back({one, t_ent'(0), t_ent'(0), t_ent'(0), t_ent'(0), one,
                                t_ent'(0), one, t_ent'(0)});
        pending_mats.push_back(diag(t_ent'(16), t_ent'(16), t_ent'(16)));
        pending_mats.push_back(diag(t_ent'(1 << 12), t_ent'(1 << 12), t_ent'(1 << 12)));
        pending_mats.push_back({mx, mn, mx, mn, mx, mn, mx, mn, mx});
        pending_mats.push_back({mx, t_ent'(1), t_ent'(0), t_ent'(-1), mn, t_ent'(2),
                                t_ent'(3), t_ent'(0), mx});

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_eps(eps_list[ph]);
                // tiny matrices, huge inverses: overflow only visible with small epsilon
                pending_mats.push_back(diag(t_ent'(16), t_ent'(-16), t_ent'(16)));
                pending_mats.push_back(diag(one, t_ent'(1), one));
            end
            no_gaps = (ph == 2);
            for (int n = 0; n < 485; n++) pending_mats.push_back(rand_matrix());
        end
        wait_idle();
        if (bad_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
